### hdl/htw_pkg.sv
package htw_pkg;

	localparam int CMD_W = 2;
	localparam int TID_W = 6;
	localparam int DUR_W = 24;
	localparam int CNT_W = 7;
	localparam int EXP_W = 32;

	localparam int DEF_SPOKE_COUNT = 4096;
	localparam int DEF_NUM_TIMERS = 64;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	typedef enum logic [1:0] {
		K_TICK,
		K_START,
		K_STOP,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [TID_W-1:0]   tid;
		logic [DUR_W-1:0]   dur;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} q_t;

	typedef struct packed {
		logic               expired_valid;
		logic [TID_W-1:0]   expired_id;
		logic               last;
		logic [CNT_W-1:0]   running_count;
		logic [EXP_W-1:0]   expiration_count;
	} res_t;

endpackage

### hdl/htw_if.sv
interface htw_req_if;
	logic                        valid;
	logic                        ready;
	logic [htw_pkg::CMD_W-1:0]   cmd;
	logic [htw_pkg::TID_W-1:0]   timer_id;
	logic [htw_pkg::DUR_W-1:0]   duration;

	modport source(output valid, cmd, timer_id, duration, input ready);
	modport sink(input valid, cmd, timer_id, duration, output ready);
endinterface

interface htw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        expired_valid;
	logic [htw_pkg::TID_W-1:0]   expired_id;
	logic                        last;
	logic [htw_pkg::CNT_W-1:0]   running_count;
	logic [htw_pkg::EXP_W-1:0]   expiration_count;

	modport source(output valid, expired_valid, expired_id, last, running_count,
		expiration_count, input ready);
	modport sink(input valid, expired_valid, expired_id, last, running_count,
		expiration_count, output ready);
endinterface

### hdl/htw_front.sv
module htw_front #(
	parameter int NUM_TIMERS = htw_pkg::DEF_NUM_TIMERS
) (
	input  logic          clk,
	input  logic          arst_n,
	htw_req_if.sink       req,
	input  logic          init_done,
	input  logic          pop,
	output htw_pkg::q_t   q
);

	htw_pkg::job_t slots_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;
	htw_pkg::job_t job_in;
	logic          push;
	logic          do_pop;

	// classify the command
	always_comb begin
		job_in.tid = req.timer_id;
		job_in.dur = req.duration;
		if (req.cmd == htw_pkg::CMD_TICK) begin
			job_in.kind = htw_pkg::K_TICK;
		end else if ({1'b0, req.timer_id} >= 7'(NUM_TIMERS)) begin
			job_in.kind = htw_pkg::K_NOP;
		end else if (req.cmd == htw_pkg::CMD_START) begin
			job_in.kind = htw_pkg::K_START;
		end else if (req.cmd == htw_pkg::CMD_STOP) begin
			job_in.kind = htw_pkg::K_STOP;
		end else begin
			job_in.kind = htw_pkg::K_NOP;
		end
	end

	assign req.ready = init_done && (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q.valid   = (cnt_q != 2'd0);
	assign q.job     = slots_q[rptr_q];
	assign do_pop    = pop && q.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### hdl/htw_back.sv
module htw_back #(
	parameter int SPOKE_COUNT = htw_pkg::DEF_SPOKE_COUNT,
	parameter int NUM_TIMERS = htw_pkg::DEF_NUM_TIMERS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  htw_pkg::q_t   q,
	output logic          pop,
	output logic          init_done,
	htw_rsp_if.source     rsp
);

	localparam int DUR_W   = htw_pkg::DUR_W;
	localparam int SPOKE_W = $clog2(SPOKE_COUNT);
	localparam int LINK_W  = $clog2(NUM_TIMERS + 1);
	localparam int TIX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ROT_W   = $clog2((2**DUR_W - 1) / SPOKE_COUNT + 1);
	localparam bit IS_POW2 = (SPOKE_COUNT & (SPOKE_COUNT - 1)) == 0;
	localparam logic [LINK_W-1:0]  NIL = LINK_W'(NUM_TIMERS);
	localparam logic [SPOKE_W:0]   NS1 = (SPOKE_W + 1)'(SPOKE_COUNT);
	// reciprocal of the spoke count, exact for every duration
	localparam int RCP_W = DUR_W + 2;
	localparam longint unsigned RCP_FULL =
		((64'd1 << (DUR_W + SPOKE_W)) + 64'(SPOKE_COUNT) - 64'd1) / 64'(SPOKE_COUNT);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);

	typedef enum logic [10:0] {
		S_CLR   = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_UNL   = 11'b00000000100,
		S_DIV   = 11'b00000001000,
		S_REM   = 11'b00000010000,
		S_POS   = 11'b00000100000,
		S_APP   = 11'b00001000000,
		S_THEAD = 11'b00010000000,
		S_TRD   = 11'b00100000000,
		S_TEXE  = 11'b01000000000,
		S_RES   = 11'b10000000000
	} state_t;

	state_t                     state_q;
	logic [SPOKE_W-1:0]         clr_q;
	logic [SPOKE_W-1:0]         cur_q;
	logic [htw_pkg::CNT_W-1:0]  run_q;
	logic [htw_pkg::EXP_W-1:0]  exp_q;
	logic [NUM_TIMERS-1:0]      active_q;
	htw_pkg::job_t              job_q;
	logic [LINK_W-1:0]          walk_q;
	logic [DUR_W-1:0]           quo_q;
	logic [SPOKE_W:0]           rem_q;
	logic [SPOKE_W-1:0]         pos_q;
	logic                       pend_q;
	logic [htw_pkg::TID_W-1:0]  pend_id_q;
	logic [htw_pkg::CNT_W-1:0]  pend_run_q;
	logic [htw_pkg::EXP_W-1:0]  pend_exp_q;
	htw_pkg::res_t              out_q;
	logic                       out_valid_q;

	// wheel and timer stores
	logic [LINK_W-1:0]  head_mem [SPOKE_COUNT];
	logic [LINK_W-1:0]  tail_mem [SPOKE_COUNT];
	logic [LINK_W-1:0]  next_mem [NUM_TIMERS];
	logic [LINK_W-1:0]  prev_mem [NUM_TIMERS];
	logic [ROT_W-1:0]   rot_mem  [NUM_TIMERS];
	logic [SPOKE_W-1:0] home_mem [NUM_TIMERS];

	logic [LINK_W-1:0]  head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;
	logic [ROT_W-1:0]   rot_rd_q;
	logic [SPOKE_W-1:0] home_rd_q;

	logic               head_we, tail_we, next_we, prev_we, rot_we, home_we;
	logic [SPOKE_W-1:0] head_wa, tail_wa;
	logic [LINK_W-1:0]  head_wd, tail_wd, next_wd, prev_wd;
	logic [TIX_W-1:0]   next_wa, prev_wa, rot_wa, home_wa;
	logic [ROT_W-1:0]   rot_wd;
	logic [SPOKE_W-1:0] home_wd;
	logic [TIX_W-1:0]   tx_ra;

	logic [TIX_W-1:0]   tix;
	logic [TIX_W-1:0]   wix;
	logic [SPOKE_W-1:0] cur_next;
	logic [SPOKE_W:0]   pos_sum;
	logic [SPOKE_W-1:0] pos_calc;
	logic [DUR_W+RCP_W-1:0] div_prod;
	logic               out_free;
	logic               can_go;
	logic               unl;
	logic               emit;
	htw_pkg::res_t      emit_res;
	state_t             after_unl;

	assign tix       = job_q.tid[TIX_W-1:0];
	assign wix       = walk_q[TIX_W-1:0];
	assign cur_next  = (cur_q == SPOKE_W'(SPOKE_COUNT - 1)) ? '0 : cur_q + 1'b1;
	assign pos_sum   = {1'b0, cur_q} + rem_q;
	assign pos_calc  = (pos_sum >= NS1) ? SPOKE_W'(pos_sum - NS1) : pos_sum[SPOKE_W-1:0];
	assign div_prod  = job_q.dur * RECIP;
	assign out_free  = !out_valid_q || rsp.ready;
	assign can_go    = !pend_q || out_free;
	assign tx_ra     = (state_q == S_IDLE) ? q.job.tid[TIX_W-1:0] : wix;
	assign init_done = (state_q != S_CLR);
	assign pop       = (state_q == S_IDLE);
	assign after_unl = (job_q.kind != htw_pkg::K_START) ? S_RES : (IS_POW2 ? S_POS : S_DIV);

	always_comb begin
		head_we = 1'b0; head_wa = '0; head_wd = '0;
		tail_we = 1'b0; tail_wa = '0; tail_wd = '0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		rot_we  = 1'b0; rot_wa  = '0; rot_wd  = '0;
		home_we = 1'b0; home_wa = '0; home_wd = '0;
		unl      = 1'b0;
		emit     = 1'b0;
		emit_res = '0;
		case (state_q)
			S_CLR: begin
				head_we = 1'b1; head_wa = clr_q; head_wd = NIL;
				tail_we = 1'b1; tail_wa = clr_q; tail_wd = NIL;
			end
			S_UNL: begin
				unl = 1'b1;
			end
			S_POS: begin
				next_we = 1'b1; next_wa = tix; next_wd = NIL;
			end
			S_APP: begin
				rot_we  = 1'b1; rot_wa  = tix; rot_wd  = quo_q[ROT_W-1:0];
				home_we = 1'b1; home_wa = tix; home_wd = pos_q;
				prev_we = 1'b1; prev_wa = tix; prev_wd = tail_rd_q;
				tail_we = 1'b1; tail_wa = pos_q; tail_wd = LINK_W'(tix);
				if (tail_rd_q < NIL) begin
					next_we = 1'b1; next_wa = tail_rd_q[TIX_W-1:0]; next_wd = LINK_W'(tix);
				end else begin
					head_we = 1'b1; head_wa = pos_q; head_wd = LINK_W'(tix);
				end
			end
			S_TEXE: begin
				if (rot_rd_q != '0) begin
					rot_we = 1'b1; rot_wa = wix; rot_wd = rot_rd_q - 1'b1;
				end else if (can_go) begin
					unl  = 1'b1;
					emit = pend_q;
					emit_res = '{1'b1, pend_id_q, 1'b0, pend_run_q, pend_exp_q};
				end
			end
			S_RES: begin
				emit = out_free;
				if (job_q.kind == htw_pkg::K_TICK && pend_q) begin
					emit_res = '{1'b1, pend_id_q, 1'b1, pend_run_q, pend_exp_q};
				end else begin
					emit_res = '{1'b0, '0, 1'b1, run_q, exp_q};
				end
			end
			default: begin
			end
		endcase
		// shared unlink of the timer whose links were just read
		if (unl) begin
			if (prev_rd_q < NIL) begin
				next_we = 1'b1; next_wa = prev_rd_q[TIX_W-1:0]; next_wd = next_rd_q;
			end else begin
				head_we = 1'b1; head_wa = home_rd_q; head_wd = next_rd_q;
			end
			if (next_rd_q < NIL) begin
				prev_we = 1'b1; prev_wa = next_rd_q[TIX_W-1:0]; prev_wd = prev_rd_q;
			end else begin
				tail_we = 1'b1; tail_wa = home_rd_q; tail_wd = prev_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[cur_next];
	end

	always_ff @(posedge clk) begin
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		tail_rd_q <= tail_mem[pos_calc];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[tx_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[tx_ra];
	end

	always_ff @(posedge clk) begin
		if (rot_we) rot_mem[rot_wa] <= rot_wd;
		rot_rd_q <= rot_mem[tx_ra];
	end

	always_ff @(posedge clk) begin
		if (home_we) home_mem[home_wa] <= home_wd;
		home_rd_q <= home_mem[tx_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q.valid) begin
			job_q  <= q.job;
			if (IS_POW2) begin
				quo_q <= q.job.dur >> SPOKE_W;
				rem_q <= (SPOKE_W + 1)'(q.job.dur[SPOKE_W-1:0]);
			end else begin
				quo_q <= q.job.dur;
				rem_q <= '0;
			end
		end else if (state_q == S_DIV) begin
			// quotient by reciprocal multiplication
			quo_q <= DUR_W'(div_prod >> (DUR_W + SPOKE_W));
		end else if (state_q == S_REM) begin
			rem_q <= (SPOKE_W + 1)'(job_q.dur) - (SPOKE_W + 1)'(quo_q * NS1);
		end
		if (state_q == S_POS) begin
			pos_q <= pos_calc;
		end
		if (state_q == S_TEXE && rot_rd_q == '0 && can_go) begin
			pend_id_q  <= htw_pkg::TID_W'(wix);
			pend_run_q <= run_q - 1'b1;
			pend_exp_q <= exp_q + 1'b1;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cur_q       <= '0;
			run_q       <= '0;
			exp_q       <= '0;
			active_q    <= '0;
			walk_q      <= NIL;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SPOKE_W'(SPOKE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q.valid) begin
						pend_q <= 1'b0;
						case (q.job.kind)
							htw_pkg::K_TICK: begin
								cur_q   <= cur_next;
								state_q <= S_THEAD;
							end
							htw_pkg::K_START, htw_pkg::K_STOP: begin
								if (active_q[q.job.tid[TIX_W-1:0]]) begin
									state_q <= S_UNL;
								end else if (q.job.kind == htw_pkg::K_START) begin
									state_q <= IS_POW2 ? S_POS : S_DIV;
								end else begin
									state_q <= S_RES;
								end
							end
							default: begin
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_UNL: begin
					active_q[tix] <= 1'b0;
					run_q         <= run_q - 1'b1;
					state_q       <= after_unl;
				end
				S_DIV: begin
					state_q <= S_REM;
				end
				S_REM: begin
					state_q <= S_POS;
				end
				S_POS: begin
					state_q <= S_APP;
				end
				S_APP: begin
					active_q[tix] <= 1'b1;
					run_q         <= run_q + 1'b1;
					state_q       <= S_RES;
				end
				S_THEAD: begin
					walk_q  <= head_rd_q;
					state_q <= S_TRD;
				end
				S_TRD: begin
					state_q <= (walk_q < NIL) ? S_TEXE : S_RES;
				end
				S_TEXE: begin
					if (rot_rd_q != '0) begin
						walk_q  <= next_rd_q;
						state_q <= S_TRD;
					end else if (can_go) begin
						active_q[wix] <= 1'b0;
						run_q         <= run_q - 1'b1;
						exp_q         <= exp_q + 1'b1;
						pend_q        <= 1'b1;
						walk_q        <= next_rd_q;
						state_q       <= S_TRD;
					end
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.expired_valid    = out_q.expired_valid;
	assign rsp.expired_id       = out_q.expired_id;
	assign rsp.last             = out_q.last;
	assign rsp.running_count    = out_q.running_count;
	assign rsp.expiration_count = out_q.expiration_count;

endmodule

### hdl/hashed_timer_wheel.sv
// hashed timing wheel over a pool of NUM_TIMERS timers and SPOKE_COUNT spokes. commands arrive
// on req (tick, start/restart, stop) and every command ends with exactly one result on rsp
// that has last set; a tick gives one result per expired timer in spoke order, the final one
// marked last, or a single plain result when nothing expires. a timer whose duration is a
// whole number of wheel turns (zero included) fires one full turn late, as the classic scheme
// does. after reset the spoke head and tail stores are swept to empty, one spoke per cycle,
// and req.ready stays low until the sweep is done. the front stage classifies each transfer and
// holds up to two commands; the back sequencer works on one command at a time against
// timer stores with registered reads. in the back a stop unlinks a running timer; a start
// unlinks it on a restart, divides by reciprocal when SPOKE_COUNT is not a power of two and
// links it at the tail of its spoke; a tick walks the list linked on the new spoke. a
// result waits in an output register, so the back keeps going while rsp is stalled until the
// next result is due
module hashed_timer_wheel #(
	parameter int SPOKE_COUNT = htw_pkg::DEF_SPOKE_COUNT,
	parameter int NUM_TIMERS = htw_pkg::DEF_NUM_TIMERS
) (
	input  logic      clk,
	input  logic      arst_n,
	htw_req_if.sink   req,
	htw_rsp_if.source rsp
);

	// queue between the front and the sequencer
	htw_pkg::q_t q;
	logic        pop;
	logic        init_done;

	htw_front #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.init_done (init_done),
		.pop       (pop),
		.q         (q)
	);

	// list walking, linking and result generation
	htw_back #(
		.SPOKE_COUNT (SPOKE_COUNT),
		.NUM_TIMERS  (NUM_TIMERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q         (q),
		.pop       (pop),
		.init_done (init_done),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	// a result without an expiry only ever closes a command
	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.expired_valid |-> rsp.last && rsp.expired_id == '0)
		else $error("plain result not marked last");

	// the linked count never exceeds the pool
	a_running_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.running_count <= htw_pkg::CNT_W'(NUM_TIMERS))
		else $error("running count beyond pool size");
`endif

endmodule

### sim/hashed_timer_wheel_tb.sv
module hashed_timer_wheel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPOKES = htw_pkg::DEF_SPOKE_COUNT;
	localparam int TIMERS = htw_pkg::DEF_NUM_TIMERS;
	localparam int NIL = TIMERS;
	localparam int N_RANDOM = 80;
	// a stalled side can hold the handshake for a long while; the limit also covers the
	// clearing sweep after reset
	localparam int IDLE_LIMIT = SPOKES + 20000;
	// the largest code on the command field, which the block treats as a no-op
	localparam logic [htw_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [htw_pkg::DUR_W-1:0] DUR_MAX = {htw_pkg::DUR_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	htw_req_if req();
	htw_rsp_if rsp();

	hashed_timer_wheel dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the wheel, updated once per accepted command
	int wheel_head[SPOKES];
	int wheel_tail[SPOKES];
	int link_next[TIMERS];
	int link_prev[TIMERS];
	int turns_left[TIMERS];
	int home_of[TIMERS];
	bit armed[TIMERS];
	int cur_spoke;
	logic [htw_pkg::CNT_W-1:0] live_timers;
	logic [htw_pkg::EXP_W-1:0] fired_total;

	htw_pkg::res_t pending_results[$];
	int mismatches = 0;
	int transfers_in = 0;
	int transfers_out = 0;
	int fired_seen = 0;
	int last_pushed = 0;
	bit timed_out = 0;
	bit no_gaps = 0;
	bit sent_all = 0;

	typedef struct {
		logic [htw_pkg::CMD_W-1:0] cmd;
		logic [htw_pkg::TID_W-1:0] tid;
		logic [htw_pkg::DUR_W-1:0] dur;
		bit                        typed;
		htw_pkg::res_t             want;
	} row_t;

	function automatic void clear_wheel();
		for (int s = 0; s < SPOKES; s++) begin
			wheel_head[s] = NIL;
			wheel_tail[s] = NIL;
		end
		for (int t = 0; t < TIMERS; t++) begin
			armed[t] = 0;
			link_next[t] = 0;
			link_prev[t] = 0;
			turns_left[t] = 0;
			home_of[t] = 0;
		end
		cur_spoke = 0;
		live_timers = '0;
		fired_total = '0;
	endfunction

	function automatic void detach(int t);
		int p;
		int n;
		p = link_prev[t];
		n = link_next[t];
		if (p < NIL) link_next[p] = n; else wheel_head[home_of[t]] = n;
		if (n < NIL) link_prev[n] = p; else wheel_tail[home_of[t]] = p;
		armed[t] = 0;
		live_timers = live_timers - 1'b1;
	endfunction

	function automatic htw_pkg::res_t make_res(bit v, int id, bit lst);
		htw_pkg::res_t r;
		r.expired_valid = v;
		r.expired_id = id[htw_pkg::TID_W-1:0];
		r.last = lst;
		r.running_count = live_timers;
		r.expiration_count = fired_total;
		return r;
	endfunction

	// advances the wheel model for one command and queues what the block must report
	function automatic void predict_wheel(logic [htw_pkg::CMD_W-1:0] cmd,
		logic [htw_pkg::TID_W-1:0] tid, logic [htw_pkg::DUR_W-1:0] dur);
		int t;
		int n;
		int pos;
		int cnt;
		int idx;
		htw_pkg::res_t r;
		cnt = 0;
		idx = int'(tid);
		if (cmd == htw_pkg::CMD_TICK) begin
			cur_spoke = (cur_spoke + 1) % SPOKES;
			t = wheel_head[cur_spoke];
			while (t < NIL && cnt < TIMERS) begin
				n = link_next[t];
				if (turns_left[t] > 0) begin
					turns_left[t]--;
				end else begin
					detach(t);
					fired_total = fired_total + 1;
					pending_results.push_back(make_res(1'b1, t, 1'b0));
					cnt++;
				end
				t = n;
			end
			if (cnt > 0) begin
				r = pending_results.pop_back();
				r.last = 1'b1;
				pending_results.push_back(r);
				last_pushed = cnt;
				return;
			end
		end else if (idx < TIMERS) begin
			if (cmd == htw_pkg::CMD_START) begin
				if (armed[idx]) detach(idx);
				pos = (cur_spoke + int'(dur) % SPOKES) % SPOKES;
				turns_left[idx] = int'(dur) / SPOKES;
				home_of[idx] = pos;
				link_next[idx] = NIL;
				link_prev[idx] = wheel_tail[pos];
				if (wheel_tail[pos] < NIL) link_next[wheel_tail[pos]] = idx;
				else wheel_head[pos] = idx;
				wheel_tail[pos] = idx;
				armed[idx] = 1;
				live_timers = live_timers + 1'b1;
			end else if (cmd == htw_pkg::CMD_STOP) begin
				if (armed[idx]) detach(idx);
			end
		end
		pending_results.push_back(make_res(1'b0, 0, 1'b1));
		last_pushed = 1;
	endfunction

	function automatic bit roll_gap();
		return !no_gaps && ($urandom_range(99) < 31);
	endfunction

	function automatic logic [htw_pkg::TID_W-1:0] rnd_tid();
		return htw_pkg::TID_W'($urandom_range(TIMERS - 1));
	endfunction

	function automatic logic [htw_pkg::DUR_W-1:0] rnd_dur(int hi);
		return htw_pkg::DUR_W'($urandom_range(hi));
	endfunction

	// directed rows; expectations typed in only where they are obvious after reset
	row_t directed[$];

	function automatic row_t mk(logic [htw_pkg::CMD_W-1:0] c, int id,
		logic [htw_pkg::DUR_W-1:0] d, bit typed, bit v, int eid, int run, int fired);
		row_t r;
		r.cmd = c;
		r.tid = id[htw_pkg::TID_W-1:0];
		r.dur = d;
		r.typed = typed;
		r.want.expired_valid = v;
		r.want.expired_id = eid[htw_pkg::TID_W-1:0];
		r.want.last = 1'b1;
		r.want.running_count = run[htw_pkg::CNT_W-1:0];
		r.want.expiration_count = fired[htw_pkg::EXP_W-1:0];
		return r;
	endfunction

	task automatic send_cmd(logic [htw_pkg::CMD_W-1:0] c, logic [htw_pkg::TID_W-1:0] id,
		logic [htw_pkg::DUR_W-1:0] d);
		if (roll_gap()) begin
			req.valid <= 1'b0;
			do @(posedge clk); while (roll_gap());
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.timer_id <= id;
		req.duration <= d;
		do @(posedge clk); while (!req.ready);
		predict_wheel(c, id, d);
		transfers_in++;
	endtask

	// random traffic: starts mostly with short durations so ticks actually fire timers
	task automatic send_random();
		int k;
		logic [htw_pkg::DUR_W-1:0] d;
		k = $urandom_range(99);
		if (k < 40) begin
			if ($urandom_range(9) == 0) d = rnd_dur(int'(DUR_MAX));
			else if ($urandom_range(4) == 0) d = rnd_dur(3 * SPOKES);
			else d = rnd_dur(6);
			send_cmd(htw_pkg::CMD_START, rnd_tid(), d);
		end else if (k < 80) begin
			send_cmd(htw_pkg::CMD_TICK, rnd_tid(), rnd_dur(int'(DUR_MAX)));
		end else if (k < 95) begin
			send_cmd(htw_pkg::CMD_STOP, rnd_tid(), rnd_dur(int'(DUR_MAX)));
		end else begin
			send_cmd(CMD_UNKNOWN, rnd_tid(), rnd_dur(int'(DUR_MAX)));
		end
	endtask

	initial begin
		row_t r;
		req.valid = 1'b0;
		req.cmd = htw_pkg::CMD_TICK;
		req.timer_id = '0;
		req.duration = '0;
		clear_wheel();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: nothing running, counters at zero
		directed.push_back(mk(htw_pkg::CMD_TICK, 0, 0, 1, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_STOP, 5, 0, 1, 0, 0, 0, 0));
		directed.push_back(mk(CMD_UNKNOWN, 63, DUR_MAX, 1, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 63, DUR_MAX, 1, 0, 0, 1, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 0, 1, 1, 0, 0, 2, 0));
		directed.push_back(mk(htw_pkg::CMD_TICK, 0, 0, 1, 1, 0, 1, 1));
		// restart of a running timer, then stop of it
		directed.push_back(mk(htw_pkg::CMD_START, 63, 2, 1, 0, 0, 1, 1));
		directed.push_back(mk(htw_pkg::CMD_START, 63, 3, 1, 0, 0, 1, 1));
		directed.push_back(mk(htw_pkg::CMD_STOP, 63, 0, 1, 0, 0, 0, 1));
		// zero duration and a whole turn both fire a full rotation late
		directed.push_back(mk(htw_pkg::CMD_START, 10, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 11, htw_pkg::DUR_W'(SPOKES), 0, 0, 0, 0, 0));
		// several timers on one spoke, fired in insertion order
		directed.push_back(mk(htw_pkg::CMD_START, 20, 2, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 21, 2, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 22, htw_pkg::DUR_W'(2 + SPOKES), 0, 0, 0,
			0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 23, 2, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_STOP, 21, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_TICK, 42, 7, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_STOP, 42, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(htw_pkg::CMD_START, 42,
			DUR_MAX - htw_pkg::DUR_W'(SPOKES) + 1'b1, 0, 0, 0, 0, 0));

		foreach (directed[i]) begin
			r = directed[i];
			send_cmd(r.cmd, r.tid, r.dur);
			if (r.typed && (last_pushed != 1 || pending_results[$] !== r.want)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: expected %p, got %p", i, r.want,
						pending_results[$]);
			end
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			no_gaps = (i >= 30 && i < 50);
			send_random();
		end
		req.valid <= 1'b0;
		sent_all = 1;
	end

	// result side: random back-pressure and in-order checking
	initial begin
		htw_pkg::res_t got;
		htw_pkg::res_t want;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.expired_valid = rsp.expired_valid;
				got.expired_id = rsp.expired_id;
				got.last = rsp.last;
				got.running_count = rsp.running_count;
				got.expiration_count = rsp.expiration_count;
				transfers_out++;
				if (got.expired_valid) fired_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected %p, got %p", transfers_out, want, got);
					end
				end
			end
			rsp.ready <= !roll_gap();
		end
	end

	// watchdog on cycles without any transfer, plus the end of the run
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (!(sent_all && pending_results.size() == 0)) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
			if (quiet >= IDLE_LIMIT) begin
				timed_out = 1;
				break;
			end
		end
		if (timed_out) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			// a stray result would show up within a tick walk's time
			repeat (300) @(posedge clk);
			$display("covered %0d commands (directed table then random mix), %0d results",
				transfers_in, transfers_out);
			$display("%0d timer expiries seen, mismatches: %0d", fired_seen, mismatches);
			if (mismatches == 0 && pending_results.size() == 0) begin
				$display("Regression PASS");
			end else begin
				$display("Regression FAIL");
			end
			$finish;
		end
	end

endmodule
